// ----- src/npcp_pkg.sv -----
// ============================================================================
// npcp_pkg
// Shared types, constants and palette lookups for the nearest palette pair.
// ============================================================================
`timescale 1ns / 1ps

package npcp_pkg;

    // Curses colors per pair half, and the palette of normal and bright forms.
    localparam int COLORS      = 8;
    localparam int COLOR_W     = $clog2(COLORS);
    localparam int PAIR_W      = 2 * COLOR_W;
    localparam int NUM_ENTRIES = 2 * COLORS;
    localparam int ENTRY_W     = $clog2(NUM_ENTRIES);
    localparam int CHAN_W      = 8;
    localparam int SQ_W        = 2 * CHAN_W;
    // Sum of three squares of 8-bit differences fits in 18 bits.
    localparam int DIST_W      = SQ_W + 2;
    localparam int NUM_LEVELS  = 4;

    localparam logic [COLOR_W-1:0] INK_BLACK = COLOR_W'(0);
    localparam logic [COLOR_W-1:0] INK_WHITE = COLOR_W'(COLORS - 1);

    // Component levels that the palette uses.
    typedef enum logic [1:0] {
        LVL_00 = 2'd0,
        LVL_80 = 2'd1,
        LVL_C0 = 2'd2,
        LVL_FF = 2'd3
    } t_level;

    typedef logic [NUM_LEVELS-1:0][SQ_W-1:0] t_sq_set;

    // Word handed from cell to cell.
    typedef struct packed {
        logic                valid;
        logic [PAIR_W-1:0]   pair;
        logic                to_back;
        t_sq_set             sq_r;
        t_sq_set             sq_g;
        t_sq_set             sq_b;
        logic [DIST_W-1:0]   best;
        logic [ENTRY_W-1:0]  win;
    } t_cell_word;

    function automatic logic [CHAN_W-1:0] level_value(input t_level lvl);
        logic [CHAN_W-1:0] v;
        unique case (lvl)
            LVL_00:  v = 8'h00;
            LVL_80:  v = 8'h80;
            LVL_C0:  v = 8'hC0;
            LVL_FF:  v = 8'hFF;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

    function automatic t_level pal_red(input logic [ENTRY_W-1:0] e);
        t_level l;
        unique case (e)
            4'd1:                       l = LVL_C0;
            4'd2, 4'd6, 4'd10, 4'd14:   l = LVL_80;
            4'd3, 4'd7, 4'd11, 4'd15:   l = LVL_FF;
            default:                    l = LVL_00;
        endcase
        return l;
    endfunction

    function automatic t_level pal_green(input logic [ENTRY_W-1:0] e);
        t_level l;
        unique case (e)
            4'd1:                       l = LVL_C0;
            4'd4, 4'd6, 4'd12, 4'd14:   l = LVL_80;
            4'd5, 4'd7, 4'd13, 4'd15:   l = LVL_FF;
            default:                    l = LVL_00;
        endcase
        return l;
    endfunction

    function automatic t_level pal_blue(input logic [ENTRY_W-1:0] e);
        t_level l;
        unique case (e)
            4'd1:                       l = LVL_C0;
            4'd8, 4'd10, 4'd12, 4'd14:  l = LVL_80;
            4'd9, 4'd11, 4'd13, 4'd15:  l = LVL_FF;
            default:                    l = LVL_00;
        endcase
        return l;
    endfunction

endpackage

// ----- src/npcp_prep.sv -----
// ============================================================================
// npcp_prep
// Squares the distance of each color component to every palette level.
// ============================================================================
`timescale 1ns / 1ps

module npcp_prep (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic                         i_valid,
    input  logic [npcp_pkg::PAIR_W-1:0]  i_pair,
    input  logic [npcp_pkg::CHAN_W-1:0]  i_red,
    input  logic [npcp_pkg::CHAN_W-1:0]  i_green,
    input  logic [npcp_pkg::CHAN_W-1:0]  i_blue,
    input  logic                         i_to_back,
    output npcp_pkg::t_cell_word         o_word
);

    npcp_pkg::t_cell_word r_word;
    npcp_pkg::t_cell_word n_word;

    function automatic logic [npcp_pkg::SQ_W-1:0] sq_diff(
        input logic [npcp_pkg::CHAN_W-1:0] a,
        input logic [npcp_pkg::CHAN_W-1:0] b
    );
        logic [npcp_pkg::CHAN_W-1:0] d;
        d = (a > b) ? (a - b) : (b - a);
        return npcp_pkg::SQ_W'(d) * npcp_pkg::SQ_W'(d);
    endfunction

    always_comb begin
        n_word         = '0;
        n_word.valid   = i_valid;
        n_word.pair    = i_pair;
        n_word.to_back = i_to_back;
        for (int l = 0; l < npcp_pkg::NUM_LEVELS; l++) begin
            n_word.sq_r[l] = sq_diff(i_red,
                npcp_pkg::level_value(npcp_pkg::t_level'(l)));
            n_word.sq_g[l] = sq_diff(i_green,
                npcp_pkg::level_value(npcp_pkg::t_level'(l)));
            n_word.sq_b[l] = sq_diff(i_blue,
                npcp_pkg::level_value(npcp_pkg::t_level'(l)));
        end
        // Above any reachable distance, so the first entry always takes it.
        n_word.best = '1;
        n_word.win  = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word.valid <= 1'b0;
        end else if (i_en) begin
            r_word <= n_word;
        end
    end

    assign o_word = r_word;

endmodule

// ----- src/npcp_cell.sv -----
// ============================================================================
// npcp_cell
// One palette entry: adds its three squares and keeps the earlier minimum.
// ============================================================================
`timescale 1ns / 1ps

module npcp_cell (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic [npcp_pkg::ENTRY_W-1:0]  i_entry,
    input  npcp_pkg::t_cell_word          i_word,
    output npcp_pkg::t_cell_word          o_word
);

    npcp_pkg::t_cell_word         r_word;
    npcp_pkg::t_cell_word         n_word;
    logic [npcp_pkg::DIST_W-1:0]  entry_dist;

    always_comb begin
        entry_dist = npcp_pkg::DIST_W'(i_word.sq_r[npcp_pkg::pal_red(i_entry)])
                   + npcp_pkg::DIST_W'(i_word.sq_g[npcp_pkg::pal_green(i_entry)])
                   + npcp_pkg::DIST_W'(i_word.sq_b[npcp_pkg::pal_blue(i_entry)]);
        n_word = i_word;
        // Strict compare: on a tie the earlier entry stays.
        if (entry_dist < i_word.best) begin
            n_word.best = entry_dist;
            n_word.win  = i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word.valid <= 1'b0;
        end else if (i_en) begin
            r_word <= n_word;
        end
    end

    assign o_word = r_word;

endmodule

// ----- src/npcp_fix.sv -----
// ============================================================================
// npcp_fix
// Builds the new pair from the winner and registers the result word.
// ============================================================================
`timescale 1ns / 1ps

module npcp_fix (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  npcp_pkg::t_cell_word  i_word,
    output logic                  o_valid,
    output logic [7:0]            o_data
);

    logic                           r_valid;
    logic [7:0]                     r_data;
    logic [7:0]                     n_data;
    logic [npcp_pkg::COLOR_W-1:0]   back;
    logic [npcp_pkg::COLOR_W-1:0]   fore;
    logic [npcp_pkg::COLOR_W-1:0]   win_color;
    logic                           bold;

    always_comb begin
        win_color = i_word.win[npcp_pkg::ENTRY_W-1:1];
        back      = i_word.pair[npcp_pkg::PAIR_W-1:npcp_pkg::COLOR_W];
        fore      = i_word.pair[npcp_pkg::COLOR_W-1:0];
        bold      = 1'b0;
        if (i_word.to_back) begin
            back = win_color;
        end else begin
            fore = win_color;
            bold = i_word.win[0];
        end
        // Keep the foreground visible when it matches a plain background.
        if (!bold && (back == fore)) begin
            fore = (fore != npcp_pkg::INK_WHITE) ? npcp_pkg::INK_WHITE
                                                 : npcp_pkg::INK_BLACK;
        end
        n_data = {1'b0, bold, back, fore};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_word.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// ----- src/nearest_palette_color_pair.sv -----
// ============================================================================
// nearest_palette_color_pair
// Nearest of 16 palette entries to an RGB color, merged into a color pair.
// ============================================================================
//
// Channel  Dir  Handshake                      Payload
// s_axis   in   s_axis_tvalid / s_axis_tready  tdata: pair, red, green, blue
//                                              tuser: target_background
// m_axis   out  m_axis_tvalid / m_axis_tready  tdata: new_pair, bold_out
//
// One word is accepted per cycle unless the chain is stalled. Each word passes
// through the squaring stage, each of the 16 entry cells of the compare chain,
// and the output register.
// The whole chain advances together; when the output register holds a word
// that is not taken, every stage holds and s_axis_tready drops in that cycle.
// Reset clears the valid bits of all stages; payload registers are not reset.
//
// The squaring stage computes the squared difference of each component to
// the four levels the palette uses (0x00, 0x80, 0xC0, 0xFF). Each cell then
// picks the three squares of its own entry, adds them, and replaces the
// running best when its distance is strictly smaller, so the earliest entry
// wins on a tie. The last stage places the winning color in the foreground
// or the background and applies the same-color rule.
// ============================================================================
`timescale 1ns / 1ps

module nearest_palette_color_pair (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [5:0] current_pair, [13:6] red, [21:14] green, [29:22] blue, [31:30] zero
    input  logic [31:0] s_axis_tdata,
    // [0] target_background
    input  logic        s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [5:0] new_pair, [6] bold_out, [7] zero
    output logic [7:0]  m_axis_tdata
);

    // Stall when a result sits in the output register and is not taken.
    logic en;

    npcp_pkg::t_cell_word w_chain [npcp_pkg::NUM_ENTRIES+1];

    assign en            = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;

    npcp_prep u_prep (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (en),
        .i_valid   (s_axis_tvalid),
        .i_pair    (s_axis_tdata[5:0]),
        .i_red     (s_axis_tdata[13:6]),
        .i_green   (s_axis_tdata[21:14]),
        .i_blue    (s_axis_tdata[29:22]),
        .i_to_back (s_axis_tuser),
        .o_word    (w_chain[0])
    );

    // One cell per palette entry, in palette order.
    for (genvar g = 0; g < npcp_pkg::NUM_ENTRIES; g++) begin : g_cell
        npcp_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_entry (npcp_pkg::ENTRY_W'(g)),
            .i_word  (w_chain[g]),
            .o_word  (w_chain[g+1])
        );
    end

    npcp_fix u_fix (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_word  (w_chain[npcp_pkg::NUM_ENTRIES]),
        .o_valid (m_axis_tvalid),
        .o_data  (m_axis_tdata)
    );

endmodule

// ----- sim/tb_top.sv -----
// ============================================================================
// tb_top
// Self-checking bench for the nearest palette color pair block.
// ============================================================================
//
// Words go in on the input stream and come out on the output stream. A monitor
// watches both sides at the rising edge. Each accepted input word is passed to
// a small scoreboard. The scoreboard works out the expected pair and bold flag
// and queues them. Each accepted output word is compared against the oldest
// entry in that queue.
//
// The stimulus has two parts. A short directed part covers every palette
// entry, the black and white extremes, distance ties and the same-color rule.
// A random part of about 1350 words follows. Most of its channel values lie
// near the palette levels or halfway between them, so the random part also
// reaches ties. Both sides idle at random. One long hold on the output side
// fills the pipeline so that the input side has to stall.
// ============================================================================
`timescale 1ns / 1ps

module tb_top;

    localparam int NUM_RANDOM  = 1350;
    localparam int LATENCY     = 18;
    localparam int LONG_HOLD   = 300;
    localparam int CYCLE_LIMIT = 500000;

    // Palette in entry order; the entry index shifted right by one is the color.
    localparam bit [7:0] PAL_R [16] = '{8'h00, 8'hC0, 8'h80, 8'hFF, 8'h00, 8'h00, 8'h80, 8'hFF,
                                        8'h00, 8'h00, 8'h80, 8'hFF, 8'h00, 8'h00, 8'h80, 8'hFF};
    localparam bit [7:0] PAL_G [16] = '{8'h00, 8'hC0, 8'h00, 8'h00, 8'h80, 8'hFF, 8'h80, 8'hFF,
                                        8'h00, 8'h00, 8'h00, 8'h00, 8'h80, 8'hFF, 8'h80, 8'hFF};
    localparam bit [7:0] PAL_B [16] = '{8'h00, 8'hC0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                                        8'h80, 8'hFF, 8'h80, 8'hFF, 8'h80, 8'hFF, 8'h80, 8'hFF};

    // Channel values that sit on a palette level or halfway between two, and 0x60.
    localparam bit [7:0] HOT_LEVELS [9] = '{8'h00, 8'h40, 8'h60, 8'h80, 8'hA0,
                                            8'hC0, 8'hC0, 8'hDF, 8'hFF};

    typedef struct packed {
        logic [npcp_pkg::PAIR_W-1:0] new_pair;
        logic                        bold;
    } t_pair_result;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;   // [5:0] current_pair, [13:6] red, [21:14] green,
                                 // [29:22] blue, [31:30] zero
    logic        s_axis_tuser;   // [0] target_background
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [7:0]  m_axis_tdata;   // [5:0] new_pair, [6] bold_out, [7] zero

    // Set by the stimulus to ask the output side for one long hold.
    bit long_hold_req;
    // While set, neither side inserts idle cycles.
    bit no_idle;
    int cycle_count;

    nearest_palette_color_pair uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // Finds the nearest palette entry and merges its color into the pair.
    // On equal distances the earlier entry is kept.
    function automatic t_pair_result nearest_pair(
        input logic [npcp_pkg::PAIR_W-1:0] pair,
        input logic [7:0] red,
        input logic [7:0] green,
        input logic [7:0] blue,
        input logic to_back
    );
        logic [npcp_pkg::COLOR_W-1:0] back;
        logic [npcp_pkg::COLOR_W-1:0] fore;
        logic                         bright;
        int                           best;
        int                           sq_sum;
        int                           dr;
        int                           dg;
        int                           db;
        t_pair_result                 res;
        back   = pair[npcp_pkg::PAIR_W-1:npcp_pkg::COLOR_W];
        fore   = pair[npcp_pkg::COLOR_W-1:0];
        bright = 1'b0;
        best   = 32'h00FF_FFFF;
        for (int k = 0; k < npcp_pkg::NUM_ENTRIES; k++) begin
            dr     = int'(red) - int'(PAL_R[k]);
            dg     = int'(green) - int'(PAL_G[k]);
            db     = int'(blue) - int'(PAL_B[k]);
            sq_sum = dr * dr + dg * dg + db * db;
            if (sq_sum < best) begin
                best = sq_sum;
                if (to_back) begin
                    back = npcp_pkg::COLOR_W'(k >> 1);
                end else begin
                    fore   = npcp_pkg::COLOR_W'(k >> 1);
                    bright = k[0];
                end
            end
        end
        // Keep a normal foreground visible against a background of its own color.
        if (!bright && back == fore) begin
            fore = (fore == npcp_pkg::INK_WHITE) ? npcp_pkg::INK_BLACK
                                                 : npcp_pkg::INK_WHITE;
        end
        res.new_pair = {back, fore};
        res.bold     = bright;
        return res;
    endfunction

    // Holds the expected output words in arrival order and checks them.
    class pair_scoreboard;
        t_pair_result expected_q[$];
        int           errors;

        function new();
            errors = 0;
        endfunction

        task report_mismatch(string msg);
            $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
            errors++;
        endtask

        function void note_input(logic [31:0] data, logic user);
            expected_q.push_back(nearest_pair(data[5:0], data[13:6], data[21:14],
                                              data[29:22], user));
        endfunction

        task check_output(logic [7:0] data);
            t_pair_result exp_word;
            if (expected_q.size() == 0) begin
                report_mismatch($sformatf("unexpected output word %02h", data));
                return;
            end
            exp_word = expected_q.pop_front();
            if (data[5:0] !== exp_word.new_pair) begin
                report_mismatch($sformatf("new_pair %02h, expected %02h",
                                          data[5:0], exp_word.new_pair));
            end
            if (data[6] !== exp_word.bold) begin
                report_mismatch($sformatf("bold_out %b, expected %b",
                                          data[6], exp_word.bold));
            end
        endtask

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    pair_scoreboard board = new();

    // Mostly no gap, sometimes a few cycles, rarely a long stretch.
    function automatic int pick_gap();
        int roll;
        if (no_idle) begin
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 60) begin
            return 0;
        end else if (roll < 90) begin
            return $urandom_range(1, 3);
        end else if (roll < 98) begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(11, 40);
    endfunction

    // A channel value that is either fully random or close to a palette level.
    function automatic logic [7:0] pick_channel();
        int v;
        if ($urandom_range(0, 2) == 0) begin
            return 8'($urandom_range(0, 255));
        end
        v = int'(HOT_LEVELS[$urandom_range(0, 8)]) + $urandom_range(0, 4) - 2;
        if (v < 0) begin
            v = 0;
        end else if (v > 255) begin
            v = 255;
        end
        return 8'(v);
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Every input starts at a known value, and reset is held low at the start.
    initial begin
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= 1'b0;
        m_axis_tready <= 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // Both sides are sampled at the edge, before the block's registers update.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                board.note_input(s_axis_tdata, s_axis_tuser);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                board.check_output(m_axis_tdata);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        cycle_count = 0;
    end

    // Output side: random stalls, plus one long hold counted here on request.
    initial begin : sink
        int stall;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (long_hold_req) begin
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
                long_hold_req = 1'b0;
            end else begin
                stall = pick_gap();
                if (stall == 0) begin
                    m_axis_tready <= 1'b1;
                    @(posedge i_clk);
                end else begin
                    m_axis_tready <= 1'b0;
                    repeat (stall) @(posedge i_clk);
                end
            end
        end
    end

    // Offers one word and waits until it is taken. The valid line is only
    // lowered when a gap follows, so back-to-back words keep it high.
    task automatic send_word(input logic [npcp_pkg::PAIR_W-1:0] pair,
                             input logic [7:0] red,
                             input logic [7:0] green, input logic [7:0] blue,
                             input logic to_back);
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {2'b00, blue, green, red, pair};
        s_axis_tuser  <= to_back;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        gap = pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    initial begin : stimulus
        logic [npcp_pkg::PAIR_W-1:0] pair;
        long_hold_req = 1'b0;
        no_idle       = 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);

        // Black onto black and white onto white, in both modes. These hit the
        // same-color rule from both sides, and bright white keeps its pair.
        send_word(6'd0,  8'h00, 8'h00, 8'h00, 1'b0);
        send_word(6'd0,  8'h00, 8'h00, 8'h00, 1'b1);
        send_word(6'd63, 8'hFF, 8'hFF, 8'hFF, 1'b0);
        send_word(6'd63, 8'hFF, 8'hFF, 8'hFF, 1'b1);
        // Grey halfway between black and dark grey ties; the earlier entry wins.
        send_word(6'd21, 8'h40, 8'h40, 8'h40, 1'b0);
        send_word(6'd7,  8'h40, 8'h40, 8'h40, 1'b1);
        // Red halfway between the normal and bright forms.
        send_word(6'd9,  8'hC0, 8'h00, 8'h00, 1'b0);
        // Normal foreground picked onto a background of the same color.
        send_word(6'd48, 8'h00, 8'h80, 8'h80, 1'b0);
        // Every palette entry exactly, alternating modes and sweeping the pair.
        for (int k = 0; k < npcp_pkg::NUM_ENTRIES; k++) begin
            send_word(npcp_pkg::PAIR_W'(k * 4 + k[0]), PAL_R[k], PAL_G[k], PAL_B[k],
                      k[0]);
        end

        for (int n = 0; n < NUM_RANDOM; n++) begin
            // A stretch with no idling on either side.
            no_idle = (n >= 800 && n < 950);
            // Hold the output for a long time while words keep coming, so the
            // pipeline fills and the input has to stall.
            if (n == 400) begin
                long_hold_req = 1'b1;
            end
            pair = npcp_pkg::PAIR_W'($urandom_range(0, 63));
            // Favor pairs whose halves match, to exercise the same-color rule.
            if ($urandom_range(0, 3) == 0) begin
                pair[npcp_pkg::COLOR_W-1:0] =
                    pair[npcp_pkg::PAIR_W-1:npcp_pkg::COLOR_W];
            end
            send_word(pair, pick_channel(), pick_channel(), pick_channel(),
                      1'($urandom_range(0, 1)));
        end
        s_axis_tvalid <= 1'b0;
        no_idle = 1'b0;

        while (board.pending() != 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
        if (board.errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
